### rtl/core/assert_macros.svh
// Assertion helpers included by the SVA checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/sm4_pkg.sv
package sm4_pkg;

  localparam int unsigned Rounds = 32;
  localparam int unsigned KeyWidth = 64;

  // Configuration register indexes.
  localparam logic KeyHighIdx = 1'b0;
  localparam logic KeyLowIdx  = 1'b1;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        decrypt;
  } sm4_req_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } sm4_rsp_t;

  localparam logic [31:0] Fk0 = 32'ha3b1bac6;
  localparam logic [31:0] Fk1 = 32'h56aa3350;
  localparam logic [31:0] Fk2 = 32'h677d9197;
  localparam logic [31:0] Fk3 = 32'hb27022dc;

  localparam logic [7:0] SBox [256] = '{
    8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
    8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
    8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
    8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
    8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
    8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
    8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
    8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
    8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
    8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
    8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
    8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
    8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
    8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
    8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
  };

  function automatic logic [31:0] tau(input logic [31:0] v);
    tau = {SBox[v[31:24]], SBox[v[23:16]], SBox[v[15:8]], SBox[v[7:0]]};
  endfunction

  function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned n);
    rol = (v << n) | (v >> (32 - n));
  endfunction

  // Round function of the data path.
  function automatic logic [31:0] round_t(input logic [31:0] v);
    logic [31:0] t;
    t = tau(v);
    round_t = t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
  endfunction

  // Round function of the key schedule.
  function automatic logic [31:0] key_t(input logic [31:0] v);
    logic [31:0] t;
    t = tau(v);
    key_t = t ^ rol(t, 13) ^ rol(t, 23);
  endfunction

  // CK word i: byte j is (4i+j)*7 mod 256.
  function automatic logic [31:0] ck_word(input logic [4:0] i);
    logic [7:0] b0;
    b0 = {1'b0, i, 2'b00} * 8'd7;
    ck_word = {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
  endfunction

endpackage

### rtl/core/sm4_block_cipher_unit.sv
// SM4 ECB cipher, 128-bit key and block. Writing key_high (index 0) or key_low
// (index 1) starts a key expansion: the whitened key is loaded first, then one
// round key is produced per cycle until all ROUNDS (32) are written, and busy_o
// stays high from the write edge until then; after reset the same expansion
// runs for the all-zero key. start_i is ignored while busy_o is high.
// Once idle, one block is taken every cycle: an input register followed by
// 32 pipeline stages, one S-box round each, so result_valid_o follows an
// accepted start through the input register and all ROUNDS stages, and blocks
// stream out at one per cycle. Results are shown for one cycle only; the
// receiver cannot stall the unit.
// Round keys live in one register per round; each stage selects its key
// (stage i uses key i for encryption, key ROUNDS-1-i for decryption).
module sm4_block_cipher_unit
  import sm4_pkg::*;
#(
  parameter int unsigned ROUNDS = Rounds
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  sm4_req_t            req_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [KeyWidth-1:0] cfg_data_i,
  output logic                result_valid_o,
  output sm4_rsp_t            result_o
);

  localparam int unsigned CntW = $clog2(ROUNDS + 1);

  logic [63:0] key_high_q, key_low_q;
  logic [31:0] rk_q [ROUNDS];
  logic [31:0] kw_q [4];
  logic [CntW-1:0] kcnt_q;
  logic kbusy_q, kload_q;

  logic [31:0] knew;
  assign knew = kw_q[0] ^ key_t(kw_q[1] ^ kw_q[2] ^ kw_q[3] ^ ck_word(kcnt_q[4:0]));

  // Key registers and the serial key schedule.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      kbusy_q    <= 1'b1;
      kload_q    <= 1'b1;
      kcnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == KeyLowIdx) key_low_q <= cfg_data_i;
        else key_high_q <= cfg_data_i;
        kload_q <= 1'b1;
        kbusy_q <= 1'b1;
      end else if (kload_q) begin
        kload_q <= 1'b0;
        kcnt_q  <= '0;
      end else if (kbusy_q) begin
        if (kcnt_q == CntW'(ROUNDS - 1)) kbusy_q <= 1'b0;
        kcnt_q <= kcnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (kload_q) begin
      kw_q[0] <= key_high_q[63:32] ^ Fk0;
      kw_q[1] <= key_high_q[31:0] ^ Fk1;
      kw_q[2] <= key_low_q[63:32] ^ Fk2;
      kw_q[3] <= key_low_q[31:0] ^ Fk3;
    end else if (kbusy_q) begin
      kw_q[0] <= kw_q[1];
      kw_q[1] <= kw_q[2];
      kw_q[2] <= kw_q[3];
      kw_q[3] <= knew;
      rk_q[kcnt_q[4:0]] <= knew;
    end
  end

  assign busy_o = kbusy_q;

  // Round pipeline: stage s holds words after s rounds.
  logic        vld_q [ROUNDS+1];
  logic        dec_q [ROUNDS+1];
  logic [31:0] x_q   [ROUNDS+1][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= ROUNDS; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[0] <= start_i && !kbusy_q;
      for (int s = 1; s <= ROUNDS; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dec_q[0]  <= req_i.decrypt;
    x_q[0][0] <= req_i.block_high[63:32];
    x_q[0][1] <= req_i.block_high[31:0];
    x_q[0][2] <= req_i.block_low[63:32];
    x_q[0][3] <= req_i.block_low[31:0];
    for (int s = 0; s < ROUNDS; s++) begin
      dec_q[s+1]  <= dec_q[s];
      x_q[s+1][0] <= x_q[s][1];
      x_q[s+1][1] <= x_q[s][2];
      x_q[s+1][2] <= x_q[s][3];
      x_q[s+1][3] <= x_q[s][0] ^ round_t(x_q[s][1] ^ x_q[s][2] ^ x_q[s][3] ^
                     (dec_q[s] ? rk_q[ROUNDS-1-s] : rk_q[s]));
    end
  end

  assign result_valid_o       = vld_q[ROUNDS];
  assign result_o.result_high = {x_q[ROUNDS][3], x_q[ROUNDS][2]};
  assign result_o.result_low  = {x_q[ROUNDS][1], x_q[ROUNDS][0]};

endmodule

### rtl/core/sm4_checker.sv
`include "assert_macros.svh"
module sm4_block_cipher_unit_sva
  import sm4_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic cfg_we_i,
  input logic result_valid_o
);
  // A key write always starts an expansion.
  `ASSERT_NEXT(a_cfg_busy, clk_i, rst_ni, cfg_we_i, busy_o)
  // A taken request yields a result after the pipeline latency.
  `ASSERT_IMPL(a_lat, clk_i, rst_ni, $past(start_i && !busy_o, Rounds + 1), result_valid_o)
  // No result without a request taken earlier.
  `ASSERT_IMPL(a_nospur, clk_i, rst_ni, result_valid_o, $past(start_i && !busy_o, Rounds + 1))
endmodule

bind sm4_block_cipher_unit sm4_block_cipher_unit_sva u_sm4_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .cfg_we_i(cfg_we_i), .result_valid_o(result_valid_o)
);

### verif/sm4_checker.sv
`timescale 1ns / 1ps

module sm4_checker
  import sm4_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_o,
  input  sm4_req_t            req_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [KeyWidth-1:0] cfg_data_i,
  input  logic                result_valid_o,
  input  sm4_rsp_t            result_o,
  output int                  errors_o,
  output int                  pending_o
);

  typedef logic [31:0] key_sched_t [32];

  logic [63:0] key_hi_q, key_lo_q;
  key_sched_t  sched_q;
  sm4_rsp_t    cipher_q [$];

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] v);
    return {SBox[v[31:24]], SBox[v[23:16]], SBox[v[15:8]], SBox[v[7:0]]};
  endfunction

  function automatic key_sched_t expand(input logic [63:0] hi, input logic [63:0] lo);
    key_sched_t  rk;
    logic [31:0] k [4];
    logic [31:0] t, ck;
    k[0] = hi[63:32] ^ Fk0;
    k[1] = hi[31:0]  ^ Fk1;
    k[2] = lo[63:32] ^ Fk2;
    k[3] = lo[31:0]  ^ Fk3;
    for (int i = 0; i < 32; i++) begin
      for (int j = 0; j < 4; j++) ck[31-8*j -: 8] = 8'((4 * i + j) * 7);
      t = sub_word(k[1] ^ k[2] ^ k[3] ^ ck);
      rk[i] = k[0] ^ t ^ rotl(t, 13) ^ rotl(t, 23);
      k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = rk[i];
    end
    return rk;
  endfunction

  function automatic sm4_rsp_t cipher(input sm4_req_t r, input key_sched_t rk);
    logic [31:0] x [4];
    logic [31:0] t, nw;
    x[0] = r.block_high[63:32]; x[1] = r.block_high[31:0];
    x[2] = r.block_low[63:32];  x[3] = r.block_low[31:0];
    for (int i = 0; i < 32; i++) begin
      t = sub_word(x[1] ^ x[2] ^ x[3] ^ (r.decrypt ? rk[31-i] : rk[i]));
      nw = x[0] ^ t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
      x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nw;
    end
    return '{result_high: {x[3], x[2]}, result_low: {x[1], x[0]}};
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    sm4_rsp_t want;
    if (!rst_ni) begin
      key_hi_q = '0;
      key_lo_q = '0;
      sched_q  = expand('0, '0);
      cipher_q.delete();
    end else begin
      if (result_valid_o) begin
        if (cipher_q.size() == 0) begin
          report("unexpected result", result_o.result_high, '0);
        end else begin
          want = cipher_q.pop_front();
          if (result_o.result_high !== want.result_high)
            report("result_high", result_o.result_high, want.result_high);
          if (result_o.result_low !== want.result_low)
            report("result_low", result_o.result_low, want.result_low);
        end
      end
      if (start_i && !busy_o) cipher_q.push_back(cipher(req_i, sched_q));
      if (cfg_we_i) begin
        if (cfg_idx_i == KeyLowIdx) key_lo_q = cfg_data_i;
        else key_hi_q = cfg_data_i;
        sched_q = expand(key_hi_q, key_lo_q);
      end
    end
    pending_o = cipher_q.size();
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import sm4_pkg::*;

  localparam int unsigned Phases     = 7;
  localparam int unsigned RandPerPhase = 165;
  localparam longint     CycleLimit = 200000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  sm4_req_t            req_i = '0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = 1'b0;
  logic [KeyWidth-1:0] cfg_data_i = '0;
  logic                result_valid_o;
  sm4_rsp_t            result_o;
  int                  errors, pending;
  longint              cycles = 0;

  always #1 clk_i = ~clk_i;

  sm4_block_cipher_unit dut (.*);

  sm4_checker chk (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .result_valid_o, .result_o, .errors_o(errors), .pending_o(pending)
  );

  // Watchdog: stops a hung run and reports it as failed.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Present one request at a falling edge and hold it until the unit takes it.
  // busy_o only moves at rising edges, so its value here is the one the next
  // edge sees. start_i is left high; the caller decides the next cycle.
  task automatic send(input logic [63:0] hi, input logic [63:0] lo, input logic dec);
    start_i = 1'b1;
    req_i   = '{block_high: hi, block_low: lo, decrypt: dec};
    while (busy_o) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Random gaps between requests; gaps off for the back-to-back stretch.
  task automatic maybe_gap(input bit no_gaps);
    if (!no_gaps) begin
      while ($urandom_range(99) < 37) begin
        start_i = 1'b0;
        req_i   = '{block_high: rand64(), block_low: rand64(), decrypt: 1'($urandom)};
        @(negedge clk_i);
      end
    end
  endtask

  // Drain every outstanding request first: key writes only while idle.
  task automatic drain();
    start_i = 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_key(input logic idx, input logic [63:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < Phases; p++) begin
      // Phase 0 writes random keys too (default branch); no drain before it.
      if (p > 0) drain();
      case (p)
        1: begin
          write_key(KeyHighIdx, '1);
          write_key(KeyLowIdx, '1);
        end
        2: begin
          // Published test key; its test block is sent below.
          write_key(KeyHighIdx, 64'h0123456789abcdef);
          write_key(KeyLowIdx, 64'hfedcba9876543210);
        end
        3: write_key(KeyLowIdx, rand64());      // only one half changes
        4: write_key(KeyHighIdx, '0);
        default: begin
          write_key(KeyHighIdx, rand64());
          write_key(KeyLowIdx, rand64());
        end
      endcase

      if (p == 2) begin
        // Directed: extremes, both directions, the standard vector and its inverse.
        send(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
        send(64'h681edf34d206965e, 64'h86b3e94f536e4246, 1'b1);
        send('0, '0, 1'b0);
        send('0, '0, 1'b1);
        send('1, '1, 1'b0);
        send('1, '1, 1'b1);
        send(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
        send(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b1);
        send(64'h8000000000000000, 64'h0000000000000001, 1'b0);
        send(64'h0000000000000001, 64'h8000000000000000, 1'b1);
        // An idle gap, then two requests back-to-back.
        start_i = 1'b0;
        @(negedge clk_i);
        send('1, '0, 1'b0);
        send('0, '1, 1'b1);
        // Sender waits out the whole pipeline once.
        drain();
      end

      for (int n = 0; n < RandPerPhase; n++) begin
        maybe_gap(p == 4);
        send(rand64(), rand64(), 1'($urandom));
      end
    end

    drain();
    repeat (40) @(negedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
